// File: design/ctah_pkg.sv
// package for the counter table block: widths, defaults, operation codes
// no dependencies
package ctah_pkg;

  localparam int unsigned EntriesDefault   = 1024;
  localparam int unsigned ValueBitsDefault = 32;

  localparam int unsigned FuncW   = 2;
  localparam int unsigned IndexW  = 10;
  localparam int unsigned OperW   = 32;
  localparam int unsigned SumW    = 42;
  localparam int unsigned MinMaxW = 32;
  localparam int unsigned CountW  = 11;

  typedef enum logic [FuncW-1:0] {
    FUNC_SET   = 2'd0,
    FUNC_CLEAR = 2'd1,
    FUNC_ADD   = 2'd2,
    FUNC_HALVE = 2'd3
  } func_e;

  typedef struct packed {
    logic [FuncW-1:0]  func;
    logic [IndexW-1:0] entry_index;
    logic [OperW-1:0]  operand_value;
  } req_t;

  typedef struct packed {
    logic [SumW-1:0]    total_sum;
    logic [MinMaxW-1:0] min_value;
    logic [MinMaxW-1:0] max_value;
    logic [CountW-1:0]  active_count;
    logic               table_empty;
    logic               saturated;
  } rsp_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CLEAR,
    ST_SWEEP,
    ST_DONE
  } state_e;

endpackage

// File: design/ctah_if.sv
// valid/ready channel interface carrying one payload struct
// depends on ctah_pkg
interface ctah_req_if;
  logic            valid;
  logic            ready;
  ctah_pkg::req_t  data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface ctah_rsp_if;
  logic            valid;
  logic            ready;
  ctah_pkg::rsp_t  data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// File: design/counter_table_add_halve_aggregate_top.sv
// counter table with set, clear, add-to-all-active and halve-all-active, aggregates per item
// depends on ctah_pkg and ctah_if
// set/clear/add/halve each run a full sweep over all table entries
// items are processed one at a time, each bound by the sweep through the table memory
// reset: a clearing pass over all entries runs after reset before the first item
// the result register holds until taken; next item accepted once it is taken
module counter_table_add_halve_aggregate_top #(
  parameter int unsigned ENTRIES    = ctah_pkg::EntriesDefault,
  parameter int unsigned VALUE_BITS = ctah_pkg::ValueBitsDefault
) (
  input  logic clk_i,
  input  logic rst_ni,
  ctah_req_if.sink   req,
  ctah_rsp_if.source rsp
);
  import ctah_pkg::*;

  localparam int unsigned AddrW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int unsigned CntW  = $clog2(ENTRIES + 1);
  localparam int unsigned SumIW = VALUE_BITS + CntW;
  localparam logic [VALUE_BITS-1:0] ValMax = '1;

  // bit VALUE_BITS is the active mark
  logic [VALUE_BITS:0] mem_q [ENTRIES];
  logic [VALUE_BITS:0] rd_q;
  logic [VALUE_BITS:0] wr_data;
  logic [AddrW-1:0]    rd_addr, wr_addr;
  logic                wr_en;

  state_e state_q, state_d;
  logic [CntW-1:0] rd_ptr_q, rd_ptr_d;   // next address to read
  logic            rd_vld_q, rd_vld_d;   // rd_q holds entry at wb_ptr_q
  logic [AddrW-1:0] wb_ptr_q, wb_ptr_d;
  req_t req_q;
  logic [SumIW-1:0]      sum_q, sum_d;
  logic [VALUE_BITS-1:0] lo_q, lo_d, hi_q, hi_d;
  logic [CntW-1:0]       cnt_q, cnt_d;
  logic                  sat_q, sat_d;
  logic                  rsp_vld_q, rsp_vld_d;
  rsp_t                  rsp_q, rsp_d;
  logic                  accept;

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[wr_addr] <= wr_data;
    end
    rd_q <= mem_q[rd_addr];
  end

  assign req.ready = (state_q == ST_IDLE) && !rsp_vld_q;
  assign accept    = req.valid && req.ready;
  assign rsp.valid = rsp_vld_q;
  assign rsp.data  = rsp_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_CLEAR;
      rd_ptr_q  <= '0;
      rd_vld_q  <= 1'b0;
      rsp_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      rd_ptr_q  <= rd_ptr_d;
      rd_vld_q  <= rd_vld_d;
      rsp_vld_q <= rsp_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      req_q <= req.data;
    end
    wb_ptr_q <= wb_ptr_d;
    sum_q <= sum_d;
    lo_q  <= lo_d;
    hi_q  <= hi_d;
    cnt_q <= cnt_d;
    sat_q <= sat_d;
    rsp_q <= rsp_d;
  end

  logic [VALUE_BITS:0]   cur;
  logic [VALUE_BITS-1:0] cur_v, arg_v, new_v;
  logic                  cur_a, new_a, hit, add_sat;
  logic [VALUE_BITS:0]   add_w;
  logic                  arg_big;

  always_comb begin
    // operand clipped to the value width
    if (VALUE_BITS >= OperW) begin
      arg_v   = VALUE_BITS'(req_q.operand_value);
      arg_big = 1'b0;
    end else begin
      arg_v   = req_q.operand_value[VALUE_BITS-1:0];
      arg_big = (req_q.operand_value >> VALUE_BITS) != '0;
    end
    cur   = rd_q;
    cur_v = cur[VALUE_BITS-1:0];
    cur_a = cur[VALUE_BITS];
    hit   = (CntW'(req_q.entry_index) == CntW'(wb_ptr_q)) &&
            (32'(req_q.entry_index) < ENTRIES);
    add_w = {1'b0, cur_v} + {1'b0, arg_v};
    add_sat = cur_a && (add_w[VALUE_BITS] || arg_big);
    new_v = cur_v;
    new_a = cur_a;
    unique case (func_e'(req_q.func))
      FUNC_SET: if (hit) begin
        new_v = arg_big ? ValMax : arg_v;
        new_a = 1'b1;
      end
      FUNC_CLEAR: if (hit) begin
        new_v = '0;
        new_a = 1'b0;
      end
      FUNC_ADD: if (cur_a) begin
        new_v = add_sat ? ValMax : add_w[VALUE_BITS-1:0];
      end
      FUNC_HALVE: if (cur_a) begin
        new_v = cur_v >> 1;
      end
      default: ;
    endcase
  end

  always_comb begin
    state_d   = state_q;
    rd_ptr_d  = rd_ptr_q;
    rd_vld_d  = 1'b0;
    wb_ptr_d  = wb_ptr_q;
    rd_addr   = rd_ptr_q[AddrW-1:0];
    wr_addr   = wb_ptr_q;
    wr_en     = 1'b0;
    wr_data   = {new_a, new_v};
    sum_d = sum_q; lo_d = lo_q; hi_d = hi_q; cnt_d = cnt_q; sat_d = sat_q;
    rsp_vld_d = rsp_vld_q && !rsp.ready;
    rsp_d     = rsp_q;
    unique case (state_q)
      ST_CLEAR: begin
        wr_en   = 1'b1;
        wr_addr = rd_ptr_q[AddrW-1:0];
        wr_data = '0;
        rd_ptr_d = rd_ptr_q + 1'b1;
        if (32'(rd_ptr_q) == ENTRIES - 1) begin
          rd_ptr_d = '0;
          state_d  = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (accept) begin
          state_d = ST_SWEEP;
          rd_ptr_d = '0;
          sum_d = '0; lo_d = ValMax; hi_d = '0; cnt_d = '0; sat_d = 1'b0;
        end
      end
      ST_SWEEP: begin
        // read one entry per cycle, modify and write back the one read before
        if (32'(rd_ptr_q) < ENTRIES) begin
          rd_vld_d = 1'b1;
          wb_ptr_d = rd_ptr_q[AddrW-1:0];
          rd_ptr_d = rd_ptr_q + 1'b1;
        end
        if (rd_vld_q) begin
          wr_en = 1'b1;
          if (new_a) begin
            sum_d = sum_q + SumIW'(new_v);
            cnt_d = cnt_q + 1'b1;
            if (new_v < lo_q) lo_d = new_v;
            if (new_v > hi_q) hi_d = new_v;
          end
          if (func_e'(req_q.func) == FUNC_ADD && add_sat) sat_d = 1'b1;
        end else if (32'(rd_ptr_q) >= ENTRIES) begin
          state_d = ST_DONE;
        end
      end
      ST_DONE: begin
        rsp_vld_d = 1'b1;
        rsp_d.total_sum    = SumW'(sum_q);
        rsp_d.min_value    = (cnt_q == '0) ? '0 : MinMaxW'(lo_q);
        rsp_d.max_value    = MinMaxW'(hi_q);
        rsp_d.active_count = CountW'(cnt_q);
        rsp_d.table_empty  = (cnt_q == '0);
        rsp_d.saturated    = sat_q;
        rd_ptr_d = '0;
        state_d  = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

endmodule
